FILE: hw/rtl/cvsb_pkg.sv
// ----------------------------------------------------------------------------
// cvsb_pkg: shared types and constants for the contact velocity block
// Field structs of both channels, the sideband that rides the pipeline, the
// fixed-point widths and the velocity saturation function.
// ----------------------------------------------------------------------------
`default_nettype none

package cvsb_pkg;

   localparam int VEL_W   = 24;                  // velocity, Q11.12
   localparam int NRM_W   = 16;                  // normal and slope, Q1.14
   localparam int NY_W    = NRM_W + 1;           // magnitude of a normal component
   localparam int NFRAC   = 14;                  // fraction bits of the normal
   localparam int RND     = 1 << (NFRAC - 1);    // half an LSB after the shift
   localparam int P_W     = VEL_W + NRM_W;       // v * n
   localparam int VSQ_W   = 2 * VEL_W - 1;       // v * v
   localparam int DF_W    = P_W + 2;             // full dot product
   localparam int D_W     = 28;                  // rounded dot product
   localparam int KDN_W   = 45;                  // 2 * d * n
   localparam int R_W     = 31;                  // rounded 2 * d * n
   localparam int W_W     = 30;                  // updated velocity, |w| < 2^28
   localparam int WS_W    = 28;                  // magnitude of w
   localparam int SQS_W   = 2 * WS_W;            // one square of w
   localparam int OSQ_W   = VSQ_W + 2;           // sum of squares of v
   localparam int SQ_W    = SQS_W + 2;           // sum of squares of w
   localparam int ROOT_W  = SQ_W / 2;            // root of a SQ_W word
   localparam int OLD_W   = 25;                  // old speed, below 2^25
   localparam int NUM_W   = WS_W + OLD_W + 1;    // rescale numerator
   localparam int Q_W     = OLD_W;               // rescaled magnitude
   localparam int VEL_MAX = (1 << (VEL_W - 1)) - 1;

   typedef struct packed {
      logic                    mode_bounce;
      logic                    in_front;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic signed [VEL_W-1:0] vel_z;
      logic signed [NRM_W-1:0] normal_x;
      logic signed [NRM_W-1:0] normal_y;
      logic signed [NRM_W-1:0] normal_z;
      logic signed [NRM_W-1:0] slope_in;
   } req_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x_out;
      logic signed [VEL_W-1:0] vel_y_out;
      logic signed [VEL_W-1:0] vel_z_out;
      logic signed [NRM_W-1:0] slope_out;
      logic                    adjusted;
   } rsp_type;

   // travels alongside the root and divide pipelines
   typedef struct packed {
      logic                       bounce_act;
      logic                       adjusted;
      logic [2:0][VEL_W-1:0]      res;
      logic [2:0]                 neg;
      logic [2:0][WS_W-1:0]       ws;
      logic [NRM_W-1:0]           slope;
   } side_type;

   function automatic logic [VEL_W-1:0] sat_vel(input logic signed [W_W-1:0] x);
      logic signed [W_W-1:0] hi;
      logic signed [W_W-1:0] lo;
      hi = W_W'(VEL_MAX);
      lo = -hi - W_W'(1);
      return (x > hi) ? hi[VEL_W-1:0] : ((x < lo) ? lo[VEL_W-1:0] : x[VEL_W-1:0]);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cvsb_front.sv
// ----------------------------------------------------------------------------
// cvsb_front: dot product, velocity update and squares
// Six register stages: products, dot product and rounding, scaled normal,
// new velocity, squares of the new velocity, sums of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module cvsb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  cvsb_pkg::req_type           in_data,
   output logic                        out_valid,
   output cvsb_pkg::side_type          out_side,
   output logic [cvsb_pkg::SQ_W-1:0]   out_sq,
   output logic [cvsb_pkg::SQ_W-1:0]   out_oldsq
);
   import cvsb_pkg::*;

   logic [5:0] vld_ff;

   logic signed [VEL_W-1:0] v_in [3];
   logic signed [NRM_W-1:0] n_in [3];
   logic signed [NY_W-1:0]  any_in;

   logic                    bounce1_ff, front1_ff;
   logic signed [VEL_W-1:0] v1_ff [3];
   logic signed [NRM_W-1:0] n1_ff [3];
   logic signed [P_W-1:0]   p1_ff [3], p1_in [3];
   logic [VSQ_W-1:0]        vsq1_ff [3], vsq1_in [3];
   logic signed [NRM_W-1:0] slope1_ff, slope1_in;

   logic                    bounce2_ff, act2_ff, act2_in;
   logic signed [VEL_W-1:0] v2_ff [3];
   logic signed [NRM_W-1:0] n2_ff [3];
   logic signed [DF_W-1:0]  dfull_in, dsum_in;
   logic signed [D_W-1:0]   d2_ff, d2_in;
   logic [OSQ_W-1:0]        oldsq2_ff, oldsq2_in;
   logic signed [NRM_W-1:0] slope2_ff;

   logic                    bounce3_ff, act3_ff;
   logic signed [VEL_W-1:0] v3_ff [3];
   logic signed [KDN_W-1:0] kdn3_ff [3], kdn3_in [3], prod3_in [3];
   logic [OSQ_W-1:0]        oldsq3_ff;
   logic signed [NRM_W-1:0] slope3_ff;

   logic                    bounce4_ff, act4_ff;
   logic signed [VEL_W-1:0] v4_ff [3];
   logic signed [KDN_W-1:0] rsum4_in [3];
   logic signed [R_W-1:0]   r4_in [3];
   logic signed [W_W-1:0]   w4_ff [3], w4_in [3];
   logic [OSQ_W-1:0]        oldsq4_ff;
   logic signed [NRM_W-1:0] slope4_ff;

   side_type                side5_ff, side5_in;
   logic signed [W_W-1:0]   mag5_in [3];
   logic [SQS_W-1:0]        sqs5_ff [3], sqs5_in [3];
   logic [OSQ_W-1:0]        oldsq5_ff;

   side_type                side6_ff;
   logic [SQ_W-1:0]         sq6_ff, sq6_in;
   logic [OSQ_W-1:0]        oldsq6_ff;

   always_comb begin
      v_in[0] = in_data.vel_x;
      v_in[1] = in_data.vel_y;
      v_in[2] = in_data.vel_z;
      n_in[0] = in_data.normal_x;
      n_in[1] = in_data.normal_y;
      n_in[2] = in_data.normal_z;
      for (int i = 0; i < 3; i++) begin
         p1_in[i]   = P_W'(v_in[i]) * P_W'(n_in[i]);
         vsq1_in[i] = VSQ_W'(v_in[i]) * VSQ_W'(v_in[i]);
      end
      // track the most level slope in slide mode
      any_in = n_in[1][NRM_W-1] ? -NY_W'(n_in[1]) : NY_W'(n_in[1]);
      slope1_in = (!in_data.mode_bounce && (any_in > NY_W'(in_data.slope_in))) ?
                  n_in[1] : in_data.slope_in;

      dfull_in  = -DF_W'(p1_ff[0]) - DF_W'(p1_ff[1]) + DF_W'(p1_ff[2]);
      act2_in   = front1_ff ? (dfull_in > 0) : (dfull_in < 0);
      dsum_in   = (dfull_in + DF_W'(RND)) >>> NFRAC;
      d2_in     = D_W'(dsum_in);
      oldsq2_in = OSQ_W'(vsq1_ff[0]) + OSQ_W'(vsq1_ff[1]) + OSQ_W'(vsq1_ff[2]);

      for (int i = 0; i < 3; i++) begin
         prod3_in[i] = KDN_W'(d2_ff) * KDN_W'(n2_ff[i]);
         kdn3_in[i]  = bounce2_ff ? (prod3_in[i] <<< 1) : prod3_in[i];
         rsum4_in[i] = (kdn3_ff[i] + KDN_W'(RND)) >>> NFRAC;
         r4_in[i]    = R_W'(rsum4_in[i]);
      end
      w4_in[0] = W_W'(R_W'(v3_ff[0]) + r4_in[0]);
      w4_in[1] = W_W'(R_W'(v3_ff[1]) + r4_in[1]);
      w4_in[2] = W_W'(R_W'(v3_ff[2]) - r4_in[2]);

      side5_in.bounce_act = act4_ff && bounce4_ff;
      side5_in.adjusted   = act4_ff;
      side5_in.slope      = slope4_ff;
      for (int i = 0; i < 3; i++) begin
         side5_in.neg[i] = w4_ff[i] < 0;
         mag5_in[i]      = side5_in.neg[i] ? -w4_ff[i] : w4_ff[i];
         side5_in.ws[i]  = mag5_in[i][WS_W-1:0];
         sqs5_in[i]      = SQS_W'(side5_in.ws[i]) * SQS_W'(side5_in.ws[i]);
         side5_in.res[i] = act4_ff ? sat_vel(w4_ff[i]) : v4_ff[i];
      end

      sq6_in = SQ_W'(sqs5_ff[0]) + SQ_W'(sqs5_ff[1]) + SQ_W'(sqs5_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bounce1_ff <= in_data.mode_bounce;
         front1_ff  <= in_data.in_front;
         slope1_ff  <= slope1_in;
         bounce2_ff <= bounce1_ff;
         act2_ff    <= act2_in;
         d2_ff      <= d2_in;
         oldsq2_ff  <= oldsq2_in;
         slope2_ff  <= slope1_ff;
         bounce3_ff <= bounce2_ff;
         act3_ff    <= act2_ff;
         oldsq3_ff  <= oldsq2_ff;
         slope3_ff  <= slope2_ff;
         bounce4_ff <= bounce3_ff;
         act4_ff    <= act3_ff;
         oldsq4_ff  <= oldsq3_ff;
         slope4_ff  <= slope3_ff;
         side5_ff   <= side5_in;
         oldsq5_ff  <= oldsq4_ff;
         side6_ff   <= side5_ff;
         sq6_ff     <= sq6_in;
         oldsq6_ff  <= oldsq5_ff;
         for (int i = 0; i < 3; i++) begin
            v1_ff[i]   <= v_in[i];
            n1_ff[i]   <= n_in[i];
            p1_ff[i]   <= p1_in[i];
            vsq1_ff[i] <= vsq1_in[i];
            v2_ff[i]   <= v1_ff[i];
            n2_ff[i]   <= n1_ff[i];
            v3_ff[i]   <= v2_ff[i];
            kdn3_ff[i] <= kdn3_in[i];
            v4_ff[i]   <= v3_ff[i];
            w4_ff[i]   <= w4_in[i];
            sqs5_ff[i] <= sqs5_in[i];
         end
      end
   end

   assign out_valid = vld_ff[5];
   assign out_side  = side6_ff;
   assign out_sq    = sq6_ff;
   assign out_oldsq = SQ_W'(oldsq6_ff);

endmodule

`default_nettype wire

FILE: hw/rtl/cvsb_sqrt.sv
// ----------------------------------------------------------------------------
// cvsb_sqrt: pipelined integer square root, two lanes
// One result bit per stage; lane 0 gives the new length, lane 1 the old speed.
// ----------------------------------------------------------------------------
`default_nettype none

module cvsb_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  cvsb_pkg::side_type            in_side,
   input  logic [cvsb_pkg::SQ_W-1:0]     in_sq,
   input  logic [cvsb_pkg::SQ_W-1:0]     in_oldsq,
   output logic                          out_valid,
   output cvsb_pkg::side_type            out_side,
   output logic [cvsb_pkg::ROOT_W-1:0]   out_len,
   output logic [cvsb_pkg::OLD_W-1:0]    out_old
);
   import cvsb_pkg::*;

   typedef struct packed {
      logic [SQ_W-1:0]   op;
      logic [ROOT_W:0]   rem;
      logic [ROOT_W-1:0] root;
   } lane_type;

   function automatic lane_type root_step(input lane_type a);
      lane_type          b;
      logic [ROOT_W+1:0] r2;
      logic [ROOT_W+1:0] trial;
      r2    = {a.rem[ROOT_W-1:0], a.op[SQ_W-1 -: 2]};
      trial = {a.root, 2'b01};
      b.op  = a.op << 2;
      if (r2 >= trial) begin
         b.rem  = (ROOT_W+1)'(r2 - trial);
         b.root = {a.root[ROOT_W-2:0], 1'b1};
      end else begin
         b.rem  = (ROOT_W+1)'(r2);
         b.root = {a.root[ROOT_W-2:0], 1'b0};
      end
      return b;
   endfunction

   logic [ROOT_W-1:0] vld_ff;
   side_type          side_ff [ROOT_W];
   lane_type          lane_ff [ROOT_W][2];
   lane_type          lane_in [ROOT_W][2];
   lane_type          seed_in [2];

   always_comb begin
      seed_in[0] = '{op: in_sq, rem: '0, root: '0};
      seed_in[1] = '{op: in_oldsq, rem: '0, root: '0};
      for (int k = 0; k < ROOT_W; k++) begin
         for (int j = 0; j < 2; j++) begin
            lane_in[k][j] = root_step((k == 0) ? seed_in[j] : lane_ff[(k == 0) ? 0 : k-1][j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ROOT_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < ROOT_W; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         for (int k = 0; k < ROOT_W; k++) begin
            lane_ff[k][0] <= lane_in[k][0];
            lane_ff[k][1] <= lane_in[k][1];
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];
   assign out_len   = lane_ff[ROOT_W-1][0].root;
   assign out_old   = lane_ff[ROOT_W-1][1].root[OLD_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/cvsb_div.sv
// ----------------------------------------------------------------------------
// cvsb_div: speed rescale, |w| * old / len rounded to nearest
// One product stage, then one restoring quotient bit per stage, three lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module cvsb_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  cvsb_pkg::side_type            in_side,
   input  logic [cvsb_pkg::ROOT_W-1:0]   in_len,
   input  logic [cvsb_pkg::OLD_W-1:0]    in_old,
   output logic                          out_valid,
   output cvsb_pkg::side_type            out_side,
   output logic [2:0][cvsb_pkg::Q_W-1:0] out_q,
   output logic                          out_len_zero
);
   import cvsb_pkg::*;

   logic [Q_W:0]      vld_ff;
   side_type          sidem_ff;
   logic [ROOT_W-1:0] lenm_ff;
   logic [NUM_W-1:0]  num_ff [3], num_in [3];

   side_type          side_ff [Q_W];
   logic [ROOT_W-1:0] len_ff [Q_W];
   logic [NUM_W-1:0]  rem_ff [Q_W][3], rem_in [Q_W][3];
   logic [Q_W-1:0]    q_ff [Q_W][3], q_in [Q_W][3];

   always_comb begin
      logic [NUM_W-1:0]  rsrc;
      logic [Q_W-1:0]    qsrc;
      logic [ROOT_W-1:0] lsrc;
      logic [NUM_W-1:0]  dvs;
      for (int j = 0; j < 3; j++) begin
         // adding half the divisor gives round to nearest
         num_in[j] = NUM_W'(in_side.ws[j]) * NUM_W'(in_old) + NUM_W'(in_len >> 1);
      end
      for (int k = 0; k < Q_W; k++) begin
         for (int j = 0; j < 3; j++) begin
            rsrc = (k == 0) ? num_ff[j] : rem_ff[(k == 0) ? 0 : k-1][j];
            qsrc = (k == 0) ? '0 : q_ff[(k == 0) ? 0 : k-1][j];
            lsrc = (k == 0) ? lenm_ff : len_ff[(k == 0) ? 0 : k-1];
            dvs  = NUM_W'(lsrc) << (Q_W - 1 - k);
            if (rsrc >= dvs) begin
               rem_in[k][j] = rsrc - dvs;
               q_in[k][j]   = {qsrc[Q_W-2:0], 1'b1};
            end else begin
               rem_in[k][j] = rsrc;
               q_in[k][j]   = {qsrc[Q_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Q_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sidem_ff   <= in_side;
         lenm_ff    <= in_len;
         side_ff[0] <= sidem_ff;
         len_ff[0]  <= lenm_ff;
         for (int k = 1; k < Q_W; k++) begin
            side_ff[k] <= side_ff[k-1];
            len_ff[k]  <= len_ff[k-1];
         end
         for (int j = 0; j < 3; j++) begin
            num_ff[j] <= num_in[j];
            for (int k = 0; k < Q_W; k++) begin
               rem_ff[k][j] <= rem_in[k][j];
               q_ff[k][j]   <= q_in[k][j];
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         out_q[j] = q_ff[Q_W-1][j];
      end
   end

   assign out_valid    = vld_ff[Q_W];
   assign out_side     = side_ff[Q_W-1];
   assign out_len_zero = (len_ff[Q_W-1] == '0);

endmodule

`default_nettype wire

FILE: hw/rtl/contact_velocity_slide_or_bounce.sv
// ----------------------------------------------------------------------------
// contact_velocity_slide_or_bounce: contact response for one body
// Pushes the velocity out of a surface: slide removes the approach term and
// tracks the most level slope, bounce reflects and keeps the old speed.
//
//   channel   dir   handshake              payload
//   req       in    req_valid / req_ready  req_data  (cvsb_pkg::req_type)
//   rsp       out   rsp_valid / rsp_ready  rsp_data  (cvsb_pkg::rsp_type)
//
// One transfer per cycle in each direction while the skid register is empty. The
// path is 6 front stages, 29 square-root stages (one root bit each), 26 rescale
// stages (one product stage plus one quotient bit each) and the output register.
// Reset clears every valid bit; the data path holds no reset.
// All stages advance together while the skid register is empty, so a result
// stalled at the output costs no input cycle until the skid register fills.
// ----------------------------------------------------------------------------
`default_nettype none

module contact_velocity_slide_or_bounce (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cvsb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cvsb_pkg::rsp_type rsp_data
);
   import cvsb_pkg::*;

   logic                  pipe_en;

   logic                  fr_valid;
   side_type              fr_side;
   logic [SQ_W-1:0]       fr_sq;
   logic [SQ_W-1:0]       fr_oldsq;

   logic                  rt_valid;
   side_type              rt_side;
   logic [ROOT_W-1:0]     rt_len;
   logic [OLD_W-1:0]      rt_old;

   logic                  dv_valid;
   side_type              dv_side;
   logic [2:0][Q_W-1:0]   dv_q;
   logic                  dv_len_zero;

   logic signed [W_W-1:0] qs_in [3];
   logic [VEL_W-1:0]      vel_in [3];
   rsp_type               res_in;

   logic                  out_vld_ff;
   rsp_type               out_ff;
   logic                  skid_vld_ff;
   rsp_type               skid_ff;

   // the whole pipeline moves only while the skid register is free
   assign pipe_en   = !skid_vld_ff;
   assign req_ready = pipe_en;

   cvsb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (pipe_en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_sq    (fr_sq),
      .out_oldsq (fr_oldsq)
   );

   cvsb_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (pipe_en),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_sq     (fr_sq),
      .in_oldsq  (fr_oldsq),
      .out_valid (rt_valid),
      .out_side  (rt_side),
      .out_len   (rt_len),
      .out_old   (rt_old)
   );

   cvsb_div u_div (
      .clock        (clock),
      .reset        (reset),
      .adv          (pipe_en),
      .in_valid     (rt_valid),
      .in_side      (rt_side),
      .in_len       (rt_len),
      .in_old       (rt_old),
      .out_valid    (dv_valid),
      .out_side     (dv_side),
      .out_q        (dv_q),
      .out_len_zero (dv_len_zero)
   );

   // pick the bounce result, or pass the slide / untouched velocity
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         qs_in[j] = dv_side.neg[j] ? -$signed(W_W'(dv_q[j])) : $signed(W_W'(dv_q[j]));
         if (dv_side.bounce_act) begin
            // a zero reflected vector stops the body
            vel_in[j] = dv_len_zero ? '0 : sat_vel(qs_in[j]);
         end else begin
            vel_in[j] = dv_side.res[j];
         end
      end
      res_in.vel_x_out = vel_in[0];
      res_in.vel_y_out = vel_in[1];
      res_in.vel_z_out = vel_in[2];
      res_in.slope_out = dv_side.slope;
      res_in.adjusted  = dv_side.adjusted;
   end

   // output register plus one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (rsp_ready || !out_vld_ff) begin
         out_vld_ff  <= skid_vld_ff || (pipe_en && dv_valid);
         skid_vld_ff <= 1'b0;
      end else if (pipe_en && dv_valid) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready || !out_vld_ff) begin
         out_ff <= skid_vld_ff ? skid_ff : res_in;
      end else if (pipe_en && dv_valid) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry held without an output entry");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp_ready && pipe_en && dv_valid |=> skid_vld_ff)
      else $error("result dropped while the output stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_vld_ff && !skid_vld_ff)
      else $error("output not empty after reset");

endmodule

`default_nettype wire

FILE: tb/contact_velocity_slide_or_bounce_checker.sv
// ----------------------------------------------------------------------------
// contact_velocity_slide_or_bounce_checker: response predictor and scoreboard
// Watches both channels, computes the expected velocity, slope and adjusted
// flag for every accepted contact and compares them in order with results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module contact_velocity_slide_or_bounce_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  cvsb_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  cvsb_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);
   import cvsb_pkg::*;

   rsp_type contact_responses[$];

   function automatic longint round_shift(input longint x);
      longint y;
      y = x + (longint'(1) << (NFRAC - 1));
      return y >>> NFRAC;
   endfunction

   function automatic longint int_root(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint clamp_vel(input longint x);
      longint hi;
      hi = (longint'(1) << (VEL_W - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
   endfunction

   function automatic rsp_type predict_contact(input req_type c);
      longint v[3], n[3], w[3], res[3];
      longint unsigned ws[3], oldsq, sq, m, old, len, q;
      longint dfull, d, k, slope;
      bit act;
      int sh;
      rsp_type r;
      v[0] = longint'(c.vel_x); v[1] = longint'(c.vel_y); v[2] = longint'(c.vel_z);
      n[0] = longint'(c.normal_x); n[1] = longint'(c.normal_y);
      n[2] = longint'(c.normal_z);
      slope = longint'(c.slope_in);
      for (int i = 0; i < 3; i++) res[i] = v[i];
      dfull = -(v[0] * n[0]) - (v[1] * n[1]) + (v[2] * n[2]);
      act = c.in_front ? (dfull > 0) : (dfull < 0);
      d = round_shift(dfull);
      if (act) begin
         k = c.mode_bounce ? 2 : 1;
         w[0] = v[0] + round_shift(k * d * n[0]);
         w[1] = v[1] + round_shift(k * d * n[1]);
         w[2] = v[2] - round_shift(k * d * n[2]);
         if (!c.mode_bounce) begin
            for (int i = 0; i < 3; i++) res[i] = w[i];
         end else begin
            oldsq = 0; m = 0; sq = 0; sh = 0;
            for (int i = 0; i < 3; i++) begin
               oldsq += longint'(v[i] < 0 ? -v[i] : v[i]) * (v[i] < 0 ? -v[i] : v[i]);
               if ((w[i] < 0 ? -w[i] : w[i]) > m) m = w[i] < 0 ? -w[i] : w[i];
            end
            old = int_root(oldsq);
            while ((m >> sh) >= (longint'(1) << 30)) sh++;
            for (int i = 0; i < 3; i++) begin
               ws[i] = (w[i] < 0 ? -w[i] : w[i]) >> sh;
               sq += ws[i] * ws[i];
            end
            len = int_root(sq);
            for (int i = 0; i < 3; i++) begin
               if (len == 0) begin
                  res[i] = 0;
               end else begin
                  q = (ws[i] * old + len / 2) / len;
                  res[i] = (w[i] < 0) ? -longint'(q) : longint'(q);
               end
            end
         end
      end
      if (!c.mode_bounce && ((n[1] < 0 ? -n[1] : n[1]) > slope)) slope = n[1];
      r.vel_x_out = VEL_W'(clamp_vel(res[0]));
      r.vel_y_out = VEL_W'(clamp_vel(res[1]));
      r.vel_z_out = VEL_W'(clamp_vel(res[2]));
      r.slope_out = NRM_W'(slope);
      r.adjusted  = act;
      return r;
   endfunction

   assign pending_count = contact_responses.size();

   always_ff @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         fail_count <= 0;
      end else begin
         // predict on the input transfer
         if (req_valid && req_ready) contact_responses.push_back(predict_contact(req_data));
         // compare on the output transfer
         if (rsp_valid && rsp_ready) begin
            if (contact_responses.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = contact_responses.pop_front();
               if (exp_rsp !== rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p actual %p", exp_rsp, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: tb/contact_velocity_slide_or_bounce_test.sv
// ----------------------------------------------------------------------------
// contact_velocity_slide_or_bounce_test: top level of the contact testbench
// Drives directed corner contacts then random ones with random gaps on both
// channels; the checker predicts and scores, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module contact_velocity_slide_or_bounce_test;
   import cvsb_pkg::*;

   localparam int LATENCY = 62;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;

   always #5 clock = ~clock;

   contact_velocity_slide_or_bounce u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   contact_velocity_slide_or_bounce_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // mostly short gaps, a few long ones, and some none at all
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // pick a component: corners, unit-range values or full-range noise
   function automatic logic [NRM_W-1:0] pick_normal();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'h0000;
         3: return NRM_W'($urandom);
         default: return NRM_W'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function automatic logic [VEL_W-1:0] pick_vel();
      case ($urandom_range(0, 6))
         0: return 24'h7fffff;
         1: return 24'h800000;
         2: return 24'h000000;
         3: return VEL_W'($urandom_range(0, 8192) - 4096);
         default: return VEL_W'($urandom);
      endcase
   endfunction

   function automatic req_type random_contact();
      req_type c;
      c.mode_bounce = 1'($urandom);
      c.in_front    = 1'($urandom);
      c.vel_x = pick_vel();
      c.vel_y = pick_vel();
      c.vel_z = pick_vel();
      c.normal_x = pick_normal();
      c.normal_y = pick_normal();
      c.normal_z = pick_normal();
      c.slope_in = pick_normal();
      return c;
   endfunction

   // present one contact and hold it until the transfer; drop valid only
   // when a gap follows
   task automatic send_contact(input req_type c);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= c;
      do @(posedge clock); while (!req_ready);
   endtask

   // randomly stall the result channel
   initial begin
      int g;
      @(negedge reset);
      forever begin
         @(posedge clock);
         rsp_ready <= 1'b1;
         @(posedge clock);
         g = gap_len();
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g - 1) @(posedge clock);
         end
      end
   end

   initial begin
      req_type c;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: both modes and sides, extreme fields, zero vectors
      for (int i = 0; i < 16; i++) begin
         c = '0;
         c.mode_bounce = i[0];
         c.in_front    = i[1];
         c.vel_x = i[2] ? 24'h7fffff : 24'h800000;
         c.vel_y = i[3] ? 24'h800000 : 24'h001000;
         c.vel_z = i[2] ? 24'h800000 : 24'h7fffff;
         c.normal_x = i[3] ? 16'sd16384 : -16'sd16384;
         c.normal_y = i[2] ? -16'sd16384 : 16'sd16384;
         c.normal_z = i[3] ? 16'sh7fff : 16'sh8000;
         c.slope_in = i[0] ? 16'sh8000 : 16'sh7fff;
         send_contact(c);
      end
      // head-on unit normal: bounce reflects v, slide (k = 1) cancels it to a zero vector
      c = '0; c.mode_bounce = 1'b1; c.in_front = 1'b1;
      c.vel_x = -24'sd4096; c.normal_x = 16'sd16384;
      send_contact(c);
      c.mode_bounce = 1'b0; send_contact(c);
      c = '0; send_contact(c);
      c.in_front = 1'b1; c.mode_bounce = 1'b1; send_contact(c);

      // random contacts
      repeat (1100) send_contact(random_contact());
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("contact_velocity_slide_or_bounce_test: PASS");
      end else begin
         $display("contact_velocity_slide_or_bounce_test: FAIL");
      end
      $finish;
   end

   // hold a hard ceiling on run time
   initial begin
      #10000000;
      $display("contact_velocity_slide_or_bounce_test: FAIL");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
hw/rtl/cvsb_pkg.sv
hw/rtl/cvsb_front.sv
hw/rtl/cvsb_sqrt.sv
hw/rtl/cvsb_div.sv
hw/rtl/contact_velocity_slide_or_bounce.sv
tb/contact_velocity_slide_or_bounce_checker.sv
tb/contact_velocity_slide_or_bounce_test.sv
